// ----- design/sfr_pkg.sv -----
// Shared constants for the stuffed frame receiver: buffer depth, status codes, register map.
package sfr_pkg;

  localparam int FRAME_BUFFER_DEPTH = 64;

  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] CFG_START_IDX  = 2'd0;
  localparam logic [1:0] CFG_END_IDX    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_IDX = 2'd2;

  localparam logic [7:0] START_RESET  = 8'd2;
  localparam logic [7:0] END_RESET    = 8'd3;
  localparam logic [7:0] ESCAPE_RESET = 8'd32;

endpackage

// ----- design/stuffed_frame_receiver_unit.sv -----
// Top level of the byte-stuffed frame receiver with XOR check byte.
// Body bytes flow at one per cycle while in_stall is low.
// A status item follows its closing byte through the command queue and the registered output
// stage; a payload run also passes the buffer's read port, then flows at one byte per cycle while out_stall is low.
// Input is held off from a good frame's closing byte until its last byte reaches the output.
// Reset (rst, synchronous, active high) restores default framing bytes and goes idle;
// the frame buffer is not cleared, since only bytes of the current frame are read back.
module stuffed_frame_receiver_unit #(
  parameter int FRAME_BUFFER_DEPTH = sfr_pkg::FRAME_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic [1:0] frame_status,
  output logic       is_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Buffer index width; the raw and decoded counters share it since neither exceeds depth-1.
  localparam int AW = $clog2(FRAME_BUFFER_DEPTH);

  logic          cmd_push;
  logic [AW+1:0] push_data;
  logic          fifo_full;
  logic          cmd_pop;
  logic          cmd_valid;
  logic [AW+1:0] cmd_data;
  logic          replay_done;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // The parser classifies each byte and writes decoded bytes straight into the buffer.
  sfr_front #(
    .D  (FRAME_BUFFER_DEPTH),
    .AW (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_push    (cmd_push),
    .cmd_data    (push_data),
    .fifo_full   (fifo_full),
    .replay_done (replay_done),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata)
  );

  // Each command is a status code plus, for good frames, the payload length.
  sfr_cmd_fifo #(
    .W (AW + 2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data)
  );

  // The sequencer turns commands into result items behind a registered output stage.
  sfr_back #(
    .D  (FRAME_BUFFER_DEPTH),
    .AW (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .cmd_valid    (cmd_valid),
    .cmd_data     (cmd_data),
    .cmd_pop      (cmd_pop),
    .replay_done  (replay_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .frame_status (frame_status),
    .is_last      (is_last)
  );

endmodule

// ----- design/sfr_cmd_fifo.sv -----
// Two-entry command queue between the frame parser and the result sequencer.
module sfr_cmd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         cmd_valid,
  output logic [W-1:0] cmd_data
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/sfr_front.sv -----
// Frame parser: configuration registers, framing, unescaping, checksum and buffer writes.
module sfr_front #(
  parameter int D  = sfr_pkg::FRAME_BUFFER_DEPTH,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    rx_byte,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output logic          cmd_push,
  output logic [AW+1:0] cmd_data,
  input  logic          fifo_full,
  input  logic          replay_done,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata
);

  logic [7:0]    start_byte;
  logic [7:0]    end_byte;
  logic [7:0]    escape_byte;

  logic          in_frame, in_frame_next;
  logic [AW-1:0] raw_count, raw_count_next;
  logic [AW-1:0] decoded_count, decoded_count_next;
  logic          escape_pending, escape_pending_next;
  logic [7:0]    running_xor, running_xor_next;
  logic          replay_pending;
  logic          accept;
  logic [1:0]    push_status;
  logic [AW-1:0] push_count;

  assign cfg_ready = 1'b1;
  // The buffer must not change while a good frame is being replayed.
  assign in_stall  = fifo_full || replay_pending;
  assign accept    = in_valid && !in_stall;
  assign mem_waddr = decoded_count;
  assign mem_wdata = escape_pending ? (rx_byte ^ escape_byte) : rx_byte;
  assign cmd_data  = {push_status, push_count};

  always_comb begin
    in_frame_next       = in_frame;
    raw_count_next      = raw_count;
    decoded_count_next  = decoded_count;
    escape_pending_next = escape_pending;
    running_xor_next    = running_xor;
    cmd_push            = 1'b0;
    push_status         = sfr_pkg::ST_PAYLOAD;
    push_count          = '0;
    mem_we              = 1'b0;
    if (accept) begin
      if (!in_frame) begin
        if (rx_byte == start_byte) begin
          in_frame_next       = 1'b1;
          raw_count_next      = '0;
          decoded_count_next  = '0;
          escape_pending_next = 1'b0;
          running_xor_next    = '0;
        end
      end else if (raw_count >= AW'(D - 1)) begin
        in_frame_next       = 1'b0;
        raw_count_next      = '0;
        decoded_count_next  = '0;
        escape_pending_next = 1'b0;
        running_xor_next    = '0;
        cmd_push            = 1'b1;
        push_status         = sfr_pkg::ST_OVERFLOW;
      end else if (rx_byte == start_byte) begin
        raw_count_next      = '0;
        decoded_count_next  = '0;
        escape_pending_next = 1'b0;
        running_xor_next    = '0;
      end else if (rx_byte == end_byte) begin
        in_frame_next       = 1'b0;
        raw_count_next      = '0;
        decoded_count_next  = '0;
        escape_pending_next = 1'b0;
        running_xor_next    = '0;
        cmd_push            = 1'b1;
        if (decoded_count < AW'(2)) begin
          push_status = sfr_pkg::ST_SHORT;
        end else if (running_xor != 8'd0) begin
          push_status = sfr_pkg::ST_MISMATCH;
        end else begin
          push_status = sfr_pkg::ST_PAYLOAD;
          push_count  = decoded_count - AW'(1);
        end
      end else begin
        raw_count_next = raw_count + AW'(1);
        if (escape_pending || (rx_byte != escape_byte)) begin
          mem_we             = 1'b1;
          decoded_count_next = decoded_count + AW'(1);
          running_xor_next   = running_xor ^ mem_wdata;
          escape_pending_next = 1'b0;
        end else begin
          escape_pending_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= sfr_pkg::START_RESET;
      end_byte       <= sfr_pkg::END_RESET;
      escape_byte    <= sfr_pkg::ESCAPE_RESET;
      in_frame       <= 1'b0;
      raw_count      <= '0;
      decoded_count  <= '0;
      escape_pending <= 1'b0;
      running_xor    <= '0;
      replay_pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfr_pkg::CFG_START_IDX:  start_byte  <= cfg_data;
          sfr_pkg::CFG_END_IDX:    end_byte    <= cfg_data;
          sfr_pkg::CFG_ESCAPE_IDX: escape_byte <= cfg_data;
          default: ;
        endcase
      end
      in_frame       <= in_frame_next;
      raw_count      <= raw_count_next;
      decoded_count  <= decoded_count_next;
      escape_pending <= escape_pending_next;
      running_xor    <= running_xor_next;
      if (cmd_push && (push_status == sfr_pkg::ST_PAYLOAD)) begin
        replay_pending <= 1'b1;
      end else if (replay_done) begin
        replay_pending <= 1'b0;
      end
    end
  end

endmodule

// ----- design/sfr_back.sv -----
// Result sequencer: holds the frame buffer and replays payloads or emits status items.
module sfr_back #(
  parameter int D  = sfr_pkg::FRAME_BUFFER_DEPTH,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          mem_we,
  input  logic [AW-1:0] mem_waddr,
  input  logic [7:0]    mem_wdata,
  input  logic          cmd_valid,
  input  logic [AW+1:0] cmd_data,
  output logic          cmd_pop,
  output logic          replay_done,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    payload_byte,
  output logic [1:0]    frame_status,
  output logic          is_last
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t        state;
  logic [7:0]    buffer [D];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] total;
  logic          slot_free;
  logic          run_last;
  logic [1:0]    cmd_status;
  logic [AW-1:0] cmd_count;

  assign cmd_status  = cmd_data[AW+1:AW];
  assign cmd_count   = cmd_data[AW-1:0];
  assign slot_free   = !out_valid || !out_stall;
  assign run_last    = (rd_ptr == AW'(total - AW'(1)));
  assign cmd_pop     = (state == IDLE) && cmd_valid && slot_free;
  assign replay_done = (state == RUN) && slot_free && run_last;

  // Read address runs one ahead so that during a run the registered read data holds buffer[rd_ptr].
  always_comb begin
    if (state == RUN && slot_free) begin
      rd_addr = rd_ptr + AW'(1);
    end else if (state == RUN) begin
      rd_addr = rd_ptr;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buffer[mem_waddr] <= mem_wdata;
    end
    rd_data <= buffer[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      rd_ptr    <= '0;
      total     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd_pop) begin
            if (cmd_status == sfr_pkg::ST_PAYLOAD) begin
              out_valid <= 1'b0;
              total     <= cmd_count;
              rd_ptr    <= '0;
              state     <= RUN;
            end else begin
              out_valid    <= 1'b1;
              payload_byte <= 8'd0;
              frame_status <= cmd_status;
              is_last      <= 1'b1;
            end
          end else if (slot_free) begin
            out_valid <= 1'b0;
          end
        end
        RUN: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            payload_byte <= rd_data;
            frame_status <= sfr_pkg::ST_PAYLOAD;
            is_last      <= run_last;
            if (run_last) begin
              state <= IDLE;
            end else begin
              rd_ptr <= rd_ptr + AW'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- design/sfr_checker.sv -----
// Port-level assertions for the frame receiver, bound to the top level.
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] payload_byte,
  input logic [1:0] frame_status,
  input logic       is_last,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [1:0] cfg_index,
  input logic [7:0] cfg_data
);

  // Error status items carry a zero byte and always end their run.
  a_status_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_status != sfr_pkg::ST_PAYLOAD)) |-> ((payload_byte == 8'd0) && is_last))
    else $error("status item with nonzero byte or without last flag");

  // A payload run is gapless: a taken non-final byte is followed at once by another payload byte.
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (frame_status == sfr_pkg::ST_PAYLOAD) && !is_last)
      |=> (out_valid && (frame_status == sfr_pkg::ST_PAYLOAD)))
    else $error("payload run broken before its last byte");

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall)
      |=> (out_valid && $stable(payload_byte) && $stable(frame_status) && $stable(is_last)))
    else $error("stalled result changed");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stuffed_frame_receiver_unit sfr_checker u_sfr_checker (.*);

// ----- tb/deframer_sb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard package: predictor of the frame receiver and checker of its output items.
package deframer_sb_pkg;
  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } rx_result_t;

  class deframer_scoreboard;
    logic [7:0] start_val;
    logic [7:0] end_val;
    logic [7:0] esc_val;
    bit         in_frame;
    bit         esc_pending;
    int         raw_cnt;
    int         dec_cnt;
    logic [7:0] xor_acc;
    logic [7:0] decoded_store [FRAME_BUFFER_DEPTH];
    rx_result_t awaited_items [$];
    int         errors;

    function new();
      start_val = START_RESET;
      end_val   = END_RESET;
      esc_val   = ESCAPE_RESET;
      in_frame  = 1'b0;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      raw_cnt     = 0;
      dec_cnt     = 0;
      esc_pending = 1'b0;
      xor_acc     = 8'h00;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_START_IDX:  start_val = val;
        CFG_END_IDX:    end_val   = val;
        CFG_ESCAPE_IDX: esc_val   = val;
        default: ;
      endcase
    endfunction

    function void push_status(logic [1:0] st);
      awaited_items.push_back('{data: 8'h00, status: st, last: 1'b1});
    endfunction

    function void keep_decoded(logic [7:0] d);
      if (dec_cnt < FRAME_BUFFER_DEPTH) begin
        decoded_store[dec_cnt] = d;
        dec_cnt++;
      end
      xor_acc = xor_acc ^ d;
    endfunction

    // Advances the receiver state by one accepted byte and queues what it should emit.
    function void note_rx_byte(logic [7:0] b);
      if (!in_frame) begin
        if (b == start_val) begin
          in_frame = 1'b1;
          clear_frame();
        end
        return;
      end
      if (raw_cnt >= FRAME_BUFFER_DEPTH - 1) begin
        in_frame = 1'b0;
        clear_frame();
        push_status(ST_OVERFLOW);
        return;
      end
      if (b == start_val) begin
        clear_frame();
        return;
      end
      if (b == end_val) begin
        in_frame = 1'b0;
        if (dec_cnt < 2) begin
          push_status(ST_SHORT);
        end else if (xor_acc != 8'h00) begin
          push_status(ST_MISMATCH);
        end else begin
          for (int i = 0; i < dec_cnt - 1; i++) begin
            awaited_items.push_back('{data: decoded_store[i], status: ST_PAYLOAD,
                                      last: (i == dec_cnt - 2)});
          end
        end
        clear_frame();
        return;
      end
      raw_cnt++;
      if (esc_pending) begin
        esc_pending = 1'b0;
        keep_decoded(b ^ esc_val);
      end else if (b == esc_val) begin
        esc_pending = 1'b1;
      end else begin
        keep_decoded(b);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("mismatch: %s", msg);
      end
    endtask

    task check_output(logic [7:0] d, logic [1:0] st, logic lst);
      rx_result_t want;
      if (awaited_items.size() == 0) begin
        report($sformatf("unexpected item data=%h status=%0d last=%b", d, st, lst));
        return;
      end
      want = awaited_items.pop_front();
      if (d !== want.data || st !== want.status || lst !== want.last) begin
        report($sformatf("got data=%h status=%0d last=%b, want data=%h status=%0d last=%b",
                         d, st, lst, want.data, want.status, want.last));
      end
    endtask
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench of the stuffed frame receiver: clock, reset, stimulus and verdict.
module tb_top;
  import sfr_pkg::*;
  import deframer_sb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  // Settling time added once every predicted item has drained, to leave some margin.
  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic       is_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  deframer_scoreboard sb;
  logic [7:0]         frame_buf [$];
  bit                 quiet;
  int                 hold_cycles;
  int                 cycle_count;
  int                 body_sent;

  stuffed_frame_receiver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .frame_status (frame_status),
    .is_last      (is_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Every item taken from the output is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_output(payload_byte, frame_status, is_last);
    end
  end

  // Output side. A requested hold-off is counted down here, so the sender keeps
  // pushing bytes until the block fills up and raises in_stall. Otherwise the
  // receiver stalls in about one cycle out of five, or never in quiet phases.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 21);
      end
    end
  end

  // Offers one byte, possibly after a short random gap, and waits until it is taken.
  // The task starts and ends at a falling edge, and leaves in_valid high so that
  // back-to-back bytes do not drop valid for a cycle.
  task automatic send_rx(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.in_frame) body_sent++;
    sb.note_rx_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_rx(frame_buf[i]);
  endtask

  function automatic bit is_special(logic [7:0] d);
    return d == sb.start_val || d == sb.end_val || d == sb.esc_val;
  endfunction

  // A byte can travel as data if it is ordinary, or if its escaped form is not
  // a framing byte. When the escape marker is itself a framing byte, no
  // special value can be sent at all.
  function automatic bit encodable(logic [7:0] d);
    if (!is_special(d)) return 1'b1;
    if (sb.esc_val == sb.start_val || sb.esc_val == sb.end_val) return 1'b0;
    return (d ^ sb.esc_val) != sb.start_val && (d ^ sb.esc_val) != sb.end_val;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (is_special(v));
    return v;
  endfunction

  function automatic void emit(logic [7:0] d);
    if (is_special(d)) begin
      frame_buf.push_back(sb.esc_val);
      frame_buf.push_back(d ^ sb.esc_val);
    end else begin
      frame_buf.push_back(d);
    end
  endfunction

  // Builds a stuffed frame with n payload bytes and its check byte. Long frames
  // use only ordinary bytes so that the raw body stays within the buffer. With
  // corrupt set, one bit of the check byte is flipped.
  function automatic void build_frame(int n, bit corrupt);
    logic [7:0] body [$];
    logic [7:0] d;
    logic [7:0] chk;
    int         tries;
    bit         plain;
    plain = (n > 20);
    for (int i = 0; i < n; i++) begin
      do begin
        if (plain) d = pick_plain();
        else if ($urandom_range(9) < 3) d = ($urandom_range(2) == 0) ? sb.start_val :
                                            ($urandom_range(1) == 0) ? sb.end_val : sb.esc_val;
        else d = 8'($urandom_range(255));
      end while (!encodable(d));
      body.push_back(d);
    end
    tries = 0;
    do begin
      chk = 8'h00;
      foreach (body[i]) chk ^= body[i];
      if ((plain ? !is_special(chk) : encodable(chk)) || tries >= 50) break;
      body[0] = pick_plain();
      tries++;
    end while (1);
    if (corrupt) chk ^= 8'h01 << $urandom_range(7);
    frame_buf.delete();
    frame_buf.push_back(sb.start_val);
    foreach (body[i]) emit(body[i]);
    emit(chk);
    frame_buf.push_back(sb.end_val);
  endfunction

  // A full raw body of ordinary bytes; the byte after it is dropped as overflow.
  function automatic void build_overflow();
    frame_buf.delete();
    frame_buf.push_back(sb.start_val);
    repeat (FRAME_BUFFER_DEPTH - 1) frame_buf.push_back(pick_plain());
    frame_buf.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed frames with random content; the rest are bad check bytes,
  // short frames, dangling escapes, restarts, line noise and overflows.
  task automatic random_traffic(input int quota);
    int stop_at;
    int kind;
    int n;
    stop_at = body_sent + quota;
    while (body_sent < stop_at) begin
      kind = $urandom_range(99);
      n = ($urandom_range(14) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      if (kind < 68) begin
        build_frame(n, 1'b0);
      end else if (kind < 75) begin
        build_frame($urandom_range(8, 1), 1'b1);
      end else if (kind < 80) begin
        frame_buf.delete();
        frame_buf.push_back(sb.start_val);
        if ($urandom_range(1)) emit(pick_plain());
        frame_buf.push_back(sb.end_val);
      end else if (kind < 85) begin
        build_frame(n, 1'b0);
        frame_buf.insert(frame_buf.size() - 1, sb.esc_val);
      end else if (kind < 90) begin
        // Partial frame cut short by a new start, sometimes right after an escape.
        build_frame(n, 1'b0);
        if ($urandom_range(1)) frame_buf.push_front(sb.esc_val);
        repeat ($urandom_range(3, 1)) frame_buf.push_front(pick_plain());
        frame_buf.push_front(sb.start_val);
      end else if (kind < 94) begin
        frame_buf.delete();
        repeat ($urandom_range(4, 1)) frame_buf.push_back(8'($urandom_range(255)));
      end else if (kind < 97) begin
        frame_buf.delete();
        frame_buf.push_back(sb.start_val);
        repeat (6) frame_buf.push_back(8'($urandom_range(255)));
        frame_buf.push_back(sb.end_val);
      end else begin
        build_overflow();
      end
      send_frame();
    end
  endtask

  // Closes any open frame, lets every predicted item drain and then waits out the
  // settling time. When start and end coincide, a frame can only be left
  // through overflow, so non-start bytes are sent until that happens.
  task automatic go_idle();
    while (sb.in_frame) begin
      send_rx(sb.end_val != sb.start_val ? sb.end_val : ~sb.start_val);
    end
    in_valid <= 1'b0;
    while (sb.awaited_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes start, end and escape in turn, keeping valid high across the three.
  task automatic load_framing(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    logic [1:0] idx  [3];
    logic [7:0] vals [3];
    idx  = '{CFG_START_IDX, CFG_END_IDX, CFG_ESCAPE_IDX};
    vals = '{s, e, x};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_framing(input bit distinct);
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] x;
    do begin
      s = 8'($urandom_range(255));
      e = 8'($urandom_range(255));
      x = 8'($urandom_range(255));
    end while (distinct && (s == e || s == x || e == x));
    load_framing(s, e, x);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_START_IDX;
    cfg_data    = 8'h00;
    quiet       = 1'b0;
    hold_cycles = 0;
    body_sent   = 0;
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset framing: start 02, end 03, escape 20.
    // Bytes outside a frame, the end byte among them, are ignored.
    frame_buf = '{8'h00, 8'hFF, 8'h03};
    send_frame();
    // Extreme data values: payload 00 FF with check byte FF.
    frame_buf = '{8'h02, 8'h00, 8'hFF, 8'hFF, 8'h03};
    send_frame();
    // Start, end and escape carried as escaped data, check byte 21.
    frame_buf = '{8'h02, 8'h20, 8'h22, 8'h20, 8'h23, 8'h20, 8'h00, 8'h21, 8'h03};
    send_frame();
    // An escaped escape decodes to zero.
    frame_buf = '{8'h02, 8'h20, 8'h20, 8'h41, 8'h41, 8'h03};
    send_frame();
    // An escape right before the end byte is dropped.
    frame_buf = '{8'h02, 8'h11, 8'h11, 8'h20, 8'h03};
    send_frame();
    // A start after an escape still restarts the frame.
    frame_buf = '{8'h02, 8'h44, 8'h20, 8'h02, 8'h05, 8'h05, 8'h03};
    send_frame();
    // Too short: no byte, then a single byte.
    frame_buf = '{8'h02, 8'h03, 8'h02, 8'h07, 8'h03};
    send_frame();
    // Check byte does not match.
    frame_buf = '{8'h02, 8'h10, 8'h11, 8'h03};
    send_frame();
    go_idle();

    // The longest good frame, with no idling on either side.
    quiet = 1'b1;
    build_frame(FRAME_BUFFER_DEPTH - 3, 1'b0);
    send_frame();
    go_idle();
    quiet = 1'b0;

    // Extremes of the framing bytes, with escape equal to start.
    load_framing(8'h00, 8'hFF, 8'h00);
    random_traffic(10);
    go_idle();

    load_framing(8'hFF, 8'h00, 8'h80);
    random_traffic(10);
    go_idle();

    load_framing(8'h01, 8'hFE, 8'hFF);
    random_traffic(10);
    go_idle();

    // Start equal to end: a second start restarts rather than closes the frame,
    // which then ends only by overflow of a full raw body.
    load_framing(8'h5A, 8'h5A, 8'hA5);
    build_overflow();
    frame_buf.insert(1, sb.start_val);
    send_frame();
    go_idle();

    // Long receiver hold-off while frames keep coming in.
    load_random_framing(1'b1);
    hold_cycles = 300;
    build_frame(8, 1'b0);
    send_frame();
    build_frame(8, 1'b0);
    send_frame();
    go_idle();

    load_random_framing(1'b0);
    random_traffic(10);
    go_idle();

    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
